>>> src/fctc_pkg.sv
// Package with shared types, widths and constants of the four-corner touch calibration.
package fctc_pkg;

  localparam int unsigned RAW_W = 12;  // raw touch reading
  localparam int unsigned BND_W = 13;  // calibrated bound, reaches 4096
  localparam int unsigned MRG_W = 9;   // margin register
  localparam int unsigned SCR_W = 11;  // screen size register
  localparam int unsigned CFG_W = 11;  // widest configuration register
  localparam int unsigned IDX_W = 2;   // configuration register index
  localparam int unsigned NUM_W = 24;  // dividend magnitude
  localparam int unsigned DVS_W = 11;  // divisor, target span up to 2046
  localparam int unsigned ACC_W = 26;  // signed projected bound

  localparam logic [RAW_W-1:0] RawMax  = 12'd4095;
  localparam logic [BND_W-1:0] MinSpan = 13'd400;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] CfgMarginX = 2'd0;
  localparam logic [IDX_W-1:0] CfgMarginY = 2'd1;
  localparam logic [IDX_W-1:0] CfgWidth   = 2'd2;
  localparam logic [IDX_W-1:0] CfgHeight  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEAN,
    ST_ORIENT,
    ST_SPAN,
    ST_MUL,
    ST_DIV,
    ST_LOW,
    ST_HIGH,
    ST_EMIT
  } fctc_state_e;

endpackage

>>> src/fctc_if.sv
// Handshake channel interfaces for raw points and calibration results.
interface fctc_point_if;
  logic                        valid;
  logic                        ready;
  logic [fctc_pkg::RAW_W-1:0]  raw_x;
  logic [fctc_pkg::RAW_W-1:0]  raw_y;

  modport source (output valid, output raw_x, output raw_y, input ready);
  modport sink   (input valid, input raw_x, input raw_y, output ready);
endinterface

interface fctc_cal_if;
  logic                        valid;
  logic                        ready;
  logic [fctc_pkg::BND_W-1:0]  x_low_bound;
  logic [fctc_pkg::BND_W-1:0]  x_high_bound;
  logic [fctc_pkg::BND_W-1:0]  y_low_bound;
  logic [fctc_pkg::BND_W-1:0]  y_high_bound;
  logic                        swap_axes;
  logic                        flip_x;
  logic                        flip_y;
  logic                        ranges_ok;

  modport source (output valid, output x_low_bound, output x_high_bound,
                  output y_low_bound, output y_high_bound, output swap_axes,
                  output flip_x, output flip_y, output ranges_ok, input ready);
  modport sink   (input valid, input x_low_bound, input x_high_bound,
                  input y_low_bound, input y_high_bound, input swap_axes,
                  input flip_x, input flip_y, input ranges_ok, output ready);
endinterface

>>> src/four_corner_touch_calibration.sv
// Four-corner touch calibration: point capture, sequencer and bound arithmetic.
// Sequence: points one to three are only stored; the fourth starts a computation that
// passes the mean and orientation states, then per axis a span state and two rounded
// divisions on the shared one-bit-per-cycle divider, then the pack state. No new points
// are taken until the result is packed, and packing waits while an earlier result stalls.
// Reset (rst_ni low, asynchronous) clears the point count and restores the default registers.
module four_corner_touch_calibration (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fctc_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [fctc_pkg::CFG_W-1:0]    cfg_data_i,
  fctc_point_if.sink                    pt_i,
  fctc_cal_if.source                    cal_o
);

  localparam int unsigned RW = fctc_pkg::RAW_W;
  localparam int unsigned BW = fctc_pkg::BND_W;
  localparam int unsigned AW = fctc_pkg::ACC_W;

  // Clamp a signed projected bound into the raw reading range.
  function automatic logic [RW-1:0] clamp_raw(input logic signed [AW-1:0] v);
    logic [RW-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({{(AW-RW){1'b0}}, fctc_pkg::RawMax})) begin
      r = fctc_pkg::RawMax;
    end else begin
      r = v[RW-1:0];
    end
    return r;
  endfunction

  fctc_pkg::fctc_state_e state_q, state_d;

  // Configuration registers.
  logic [fctc_pkg::MRG_W-1:0] margin_x_q, margin_y_q;
  logic [fctc_pkg::SCR_W-1:0] width_q, height_q;

  // Point capture.
  logic [RW-1:0] px_q [4];
  logic [RW-1:0] py_q [4];
  logic [1:0]    pcount_q;
  logic          in_acc;

  // Edge means: left, right, top, bottom for each raw coordinate.
  logic [RW-1:0] lx_q, rx_q, tx_q, bx_q, ly_q, ry_q, ty_q, by_q;

  // Orientation and per-axis raw extent.
  logic          swap_q, fx_q, fy_q;
  logic [RW-1:0] xlo_q, xhi_q, ylo_q, yhi_q;

  // Sequencer position: which axis, and which of the two divisions.
  logic          axis_q, term_q;

  // Span values of the current axis.
  logic [RW-1:0]              rspan_q;
  logic [fctc_pkg::DVS_W-1:0] tspan_q;
  logic                       szero_q;
  logic signed [AW-1:0]       pmin_q;

  // Bounds and output register.
  logic [BW-1:0] xlb_q, xhb_q, ylb_q, yhb_q;
  logic          out_valid_q;
  logic [BW-1:0] o_xl_q, o_xh_q, o_yl_q, o_yh_q;
  logic          o_swap_q, o_fx_q, o_fy_q, o_ok_q;

  // Divider connection.
  logic                       div_start, div_done;
  logic [fctc_pkg::NUM_W-1:0] div_num, div_quo;

  // Sequencer controls.
  logic out_load, out_free;

  assign in_acc   = pt_i.valid && pt_i.ready;
  assign out_free = !out_valid_q || cal_o.ready;

  //--------------------------------------------------------------------------
  // Configuration writes; each value is cut to its register width.
  //--------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_x_q <= 9'd30;
      margin_y_q <= 9'd30;
      width_q    <= 11'd480;
      height_q   <= 11'd320;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fctc_pkg::CfgMarginX: margin_x_q <= cfg_data_i[fctc_pkg::MRG_W-1:0];
        fctc_pkg::CfgMarginY: margin_y_q <= cfg_data_i[fctc_pkg::MRG_W-1:0];
        fctc_pkg::CfgWidth:   width_q    <= cfg_data_i[fctc_pkg::SCR_W-1:0];
        fctc_pkg::CfgHeight:  height_q   <= cfg_data_i[fctc_pkg::SCR_W-1:0];
        default: ;
      endcase
    end
  end

  //--------------------------------------------------------------------------
  // Next state.
  //--------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fctc_pkg::ST_IDLE: begin
        if (in_acc && pcount_q == 2'd3) begin
          state_d = fctc_pkg::ST_MEAN;
        end
      end
      fctc_pkg::ST_MEAN:   state_d = fctc_pkg::ST_ORIENT;
      fctc_pkg::ST_ORIENT: state_d = fctc_pkg::ST_SPAN;
      fctc_pkg::ST_SPAN:   state_d = fctc_pkg::ST_MUL;
      fctc_pkg::ST_MUL:    state_d = fctc_pkg::ST_DIV;
      fctc_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = term_q ? fctc_pkg::ST_HIGH : fctc_pkg::ST_LOW;
        end
      end
      fctc_pkg::ST_LOW:    state_d = fctc_pkg::ST_MUL;
      fctc_pkg::ST_HIGH:   state_d = axis_q ? fctc_pkg::ST_EMIT : fctc_pkg::ST_SPAN;
      fctc_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = fctc_pkg::ST_IDLE;
        end
      end
      default: state_d = fctc_pkg::ST_IDLE;
    endcase
  end

  //--------------------------------------------------------------------------
  // Sequencer outputs.
  //--------------------------------------------------------------------------
  always_comb begin
    pt_i.ready = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      fctc_pkg::ST_IDLE: pt_i.ready = 1'b1;
      fctc_pkg::ST_MUL:  div_start  = 1'b1;
      fctc_pkg::ST_EMIT: out_load   = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fctc_pkg::ST_IDLE;
      pcount_q    <= '0;
      axis_q      <= 1'b0;
      term_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        pcount_q <= pcount_q + 2'd1;
      end
      if (state_q == fctc_pkg::ST_ORIENT) begin
        axis_q <= 1'b0;
      end else if (state_q == fctc_pkg::ST_HIGH) begin
        axis_q <= 1'b1;
      end
      if (state_q == fctc_pkg::ST_SPAN) begin
        term_q <= 1'b0;
      end else if (state_q == fctc_pkg::ST_LOW) begin
        term_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (cal_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  //--------------------------------------------------------------------------
  // Point store and edge means. A mean is the halved sum of two corners.
  //--------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px_q[pcount_q] <= pt_i.raw_x;
      py_q[pcount_q] <= pt_i.raw_y;
    end
  end

  logic [RW:0] s_lx, s_rx, s_tx, s_bx, s_ly, s_ry, s_ty, s_by;
  always_comb begin
    s_lx = {1'b0, px_q[0]} + {1'b0, px_q[2]};
    s_rx = {1'b0, px_q[1]} + {1'b0, px_q[3]};
    s_tx = {1'b0, px_q[0]} + {1'b0, px_q[1]};
    s_bx = {1'b0, px_q[2]} + {1'b0, px_q[3]};
    s_ly = {1'b0, py_q[0]} + {1'b0, py_q[2]};
    s_ry = {1'b0, py_q[1]} + {1'b0, py_q[3]};
    s_ty = {1'b0, py_q[0]} + {1'b0, py_q[1]};
    s_by = {1'b0, py_q[2]} + {1'b0, py_q[3]};
  end

  always_ff @(posedge clk_i) begin
    if (state_q == fctc_pkg::ST_MEAN) begin
      lx_q <= s_lx[RW:1];
      rx_q <= s_rx[RW:1];
      tx_q <= s_tx[RW:1];
      bx_q <= s_bx[RW:1];
      ly_q <= s_ly[RW:1];
      ry_q <= s_ry[RW:1];
      ty_q <= s_ty[RW:1];
      by_q <= s_by[RW:1];
    end
  end

  //--------------------------------------------------------------------------
  // Orientation: the axes are exchanged when the cross spans outweigh the
  // direct spans. Each screen axis then notes its direction and extent.
  //--------------------------------------------------------------------------
  logic [RW-1:0] d_ryly, d_bxtx, d_rxlx, d_byty;
  logic [RW:0]   cross_sum, direct_sum;
  logic          swap_d;
  logic [RW-1:0] axl, axr, ayt, ayb;

  always_comb begin
    d_ryly     = (ry_q > ly_q) ? ry_q - ly_q : ly_q - ry_q;
    d_bxtx     = (bx_q > tx_q) ? bx_q - tx_q : tx_q - bx_q;
    d_rxlx     = (rx_q > lx_q) ? rx_q - lx_q : lx_q - rx_q;
    d_byty     = (by_q > ty_q) ? by_q - ty_q : ty_q - by_q;
    cross_sum  = {1'b0, d_ryly} + {1'b0, d_bxtx};
    direct_sum = {1'b0, d_rxlx} + {1'b0, d_byty};
    swap_d     = cross_sum > direct_sum;
    axl        = swap_d ? ly_q : lx_q;
    axr        = swap_d ? ry_q : rx_q;
    ayt        = swap_d ? tx_q : ty_q;
    ayb        = swap_d ? bx_q : by_q;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == fctc_pkg::ST_ORIENT) begin
      swap_q <= swap_d;
      fx_q   <= axr < axl;
      fy_q   <= ayb < ayt;
      xlo_q  <= (axl < axr) ? axl : axr;
      xhi_q  <= (axl < axr) ? axr : axl;
      ylo_q  <= (ayt < ayb) ? ayt : ayb;
      yhi_q  <= (ayt < ayb) ? ayb : ayt;
    end
  end

  //--------------------------------------------------------------------------
  // Per-axis spans. The targets sit at margin and size-1-margin; a raw or
  // target span that is not positive counts as one.
  //--------------------------------------------------------------------------
  logic [RW-1:0]              lo_sel, hi_sel;
  logic [fctc_pkg::MRG_W-1:0] m_sel;
  logic [fctc_pkg::SCR_W-1:0] s_sel;
  logic signed [RW:0]         tfar, mrg_s, tdiff;

  always_comb begin
    lo_sel = axis_q ? ylo_q : xlo_q;
    hi_sel = axis_q ? yhi_q : xhi_q;
    m_sel  = axis_q ? margin_y_q : margin_x_q;
    s_sel  = axis_q ? height_q : width_q;
    mrg_s  = $signed({{(RW+1-fctc_pkg::MRG_W){1'b0}}, m_sel});
    tfar   = $signed({{(RW+1-fctc_pkg::SCR_W){1'b0}}, s_sel}) - 13'sd1 - mrg_s;
    tdiff  = tfar - mrg_s;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == fctc_pkg::ST_SPAN) begin
      rspan_q <= (hi_sel > lo_sel) ? hi_sel - lo_sel : RW'(1);
      tspan_q <= (tfar > mrg_s) ? tdiff[fctc_pkg::DVS_W-1:0] : fctc_pkg::DVS_W'(1);
      szero_q <= s_sel == '0;
    end
  end

  //--------------------------------------------------------------------------
  // Dividends for the shared divider, rounded by adding half the divisor.
  // The first term projects the margin, the second the full screen extent.
  // A zero screen size gives an extent of minus one over a unit target span,
  // so the quotient is the negated raw span.
  //--------------------------------------------------------------------------
  logic [fctc_pkg::SCR_W-1:0]       mul_a;
  logic [fctc_pkg::SCR_W+RW-1:0]    prod;

  always_comb begin
    mul_a = term_q ? s_sel - 1'b1
                   : {{(fctc_pkg::SCR_W-fctc_pkg::MRG_W){1'b0}}, m_sel};
    prod  = mul_a * rspan_q;
    if (term_q && szero_q) begin
      div_num = {{(fctc_pkg::NUM_W-RW){1'b0}}, rspan_q};
    end else begin
      div_num = {{(fctc_pkg::NUM_W-fctc_pkg::SCR_W-RW){1'b0}}, prod}
              + {{(fctc_pkg::NUM_W-fctc_pkg::DVS_W+1){1'b0}},
                 tspan_q[fctc_pkg::DVS_W-1:1]};
    end
  end

  fctc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .dvs_i  (tspan_q),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  //--------------------------------------------------------------------------
  // Bounds: low = lo - margin term, high = low + extent term, both clamped,
  // and high is kept above low.
  //--------------------------------------------------------------------------
  logic signed [AW-1:0] quo_s, pmax;
  logic [RW-1:0]        cmin, cmax;
  logic [BW-1:0]        bmax;

  always_comb begin
    quo_s = $signed({{(AW-fctc_pkg::NUM_W){1'b0}}, div_quo});
    pmax  = szero_q ? pmin_q - quo_s : pmin_q + quo_s;
    cmin  = clamp_raw(pmin_q);
    cmax  = clamp_raw(pmax);
    bmax  = (cmax <= cmin) ? {1'b0, cmin} + BW'(1) : {1'b0, cmax};
  end

  always_ff @(posedge clk_i) begin
    if (state_q == fctc_pkg::ST_LOW) begin
      pmin_q <= $signed({{(AW-RW){1'b0}}, lo_sel}) - quo_s;
    end
    if (state_q == fctc_pkg::ST_HIGH) begin
      if (axis_q) begin
        ylb_q <= {1'b0, cmin};
        yhb_q <= bmax;
      end else begin
        xlb_q <= {1'b0, cmin};
        xhb_q <= bmax;
      end
    end
  end

  //--------------------------------------------------------------------------
  // Output register. High always exceeds low here, so the range check only
  // needs the width of each span.
  //--------------------------------------------------------------------------
  logic [BW-1:0] xspan, yspan;
  assign xspan = xhb_q - xlb_q;
  assign yspan = yhb_q - ylb_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_xl_q   <= xlb_q;
      o_xh_q   <= xhb_q;
      o_yl_q   <= ylb_q;
      o_yh_q   <= yhb_q;
      o_swap_q <= swap_q;
      o_fx_q   <= fx_q;
      o_fy_q   <= fy_q;
      o_ok_q   <= (xspan >= fctc_pkg::MinSpan) && (yspan >= fctc_pkg::MinSpan);
    end
  end

  assign cal_o.valid        = out_valid_q;
  assign cal_o.x_low_bound  = o_xl_q;
  assign cal_o.x_high_bound = o_xh_q;
  assign cal_o.y_low_bound  = o_yl_q;
  assign cal_o.y_high_bound = o_yh_q;
  assign cal_o.swap_axes    = o_swap_q;
  assign cal_o.flip_x       = o_fx_q;
  assign cal_o.flip_y       = o_fy_q;
  assign cal_o.ranges_ok    = o_ok_q;

`ifndef SYNTHESIS
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == fctc_pkg::ST_DIV)
    else $error("divider finished outside the divide state");

  a_set_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == fctc_pkg::ST_MEAN |-> pcount_q == 2'd0)
    else $error("computation started without four stored points");

  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == fctc_pkg::ST_EMIT)
    else $error("result offered without a finished computation");

  a_bounds_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (o_xh_q > o_xl_q) && (o_yh_q > o_yl_q))
    else $error("high bound not above low bound");
`endif

endmodule

>>> src/fctc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module fctc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [fctc_pkg::NUM_W-1:0]  num_i,
  input  logic [fctc_pkg::DVS_W-1:0]  dvs_i,
  output logic                        done_o,
  output logic [fctc_pkg::NUM_W-1:0]  quo_o
);

  localparam int unsigned CntW = $clog2(fctc_pkg::NUM_W);
  localparam logic [CntW-1:0] LastStep = CntW'(fctc_pkg::NUM_W - 1);

  logic [fctc_pkg::NUM_W-1:0] quo_q, quo_d;
  logic [fctc_pkg::DVS_W:0]   rem_q, rem_d;
  logic [fctc_pkg::DVS_W-1:0] dvs_q;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [fctc_pkg::DVS_W:0]   shifted;
  logic                       fits;

  always_comb begin
    shifted = {rem_q[fctc_pkg::DVS_W-1:0], quo_q[fctc_pkg::NUM_W-1]};
    fits    = shifted >= {1'b0, dvs_q};
    quo_d   = quo_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[fctc_pkg::NUM_W-2:0], fits};
      rem_d = fits ? shifted - {1'b0, dvs_q} : shifted;
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= dvs_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

>>> sim/tb.sv
// Self-checking testbench for the four-corner touch calibration block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles to let pass once nothing is expected. This covers a set that is still being
  // computed, plus some slack.
  localparam int SettleCycles = 150;

  typedef struct packed {
    logic [fctc_pkg::BND_W-1:0] x_low_bound;
    logic [fctc_pkg::BND_W-1:0] x_high_bound;
    logic [fctc_pkg::BND_W-1:0] y_low_bound;
    logic [fctc_pkg::BND_W-1:0] y_high_bound;
    logic                       swap_axes;
    logic                       flip_x;
    logic                       flip_y;
    logic                       ranges_ok;
  } cal_result_t;

  // Calibration predictor and the store of expected results. It has its own copy of
  // the registers and of the four captured corner points.
  class cal_scoreboard;
    logic [fctc_pkg::MRG_W-1:0] margin_x, margin_y;
    logic [fctc_pkg::SCR_W-1:0] scr_width, scr_height;
    logic [fctc_pkg::RAW_W-1:0] corner_x [4];
    logic [fctc_pkg::RAW_W-1:0] corner_y [4];
    logic [1:0]                 slot;
    cal_result_t                expected_q [$];
    int                         n_errors;
    int                         n_results;

    function new();
      margin_x   = 9'd30;
      margin_y   = 9'd30;
      scr_width  = 11'd480;
      scr_height = 11'd320;
      slot       = 2'd0;
      n_errors   = 0;
      n_results  = 0;
    endfunction

    function void set_reg(logic [fctc_pkg::IDX_W-1:0] idx, logic [fctc_pkg::CFG_W-1:0] data);
      case (idx)
        fctc_pkg::CfgMarginX: margin_x   = data[fctc_pkg::MRG_W-1:0];
        fctc_pkg::CfgMarginY: margin_y   = data[fctc_pkg::MRG_W-1:0];
        fctc_pkg::CfgWidth:   scr_width  = data[fctc_pkg::SCR_W-1:0];
        fctc_pkg::CfgHeight:  scr_height = data[fctc_pkg::SCR_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int clamp_raw(int v);
      if (v < 0) return 0;
      if (v > int'(fctc_pkg::RawMax)) return int'(fctc_pkg::RawMax);
      return v;
    endfunction

    function int abs_diff(int a, int b);
      return (a > b) ? a - b : b - a;
    endfunction

    // Scale the span between the inset targets out to the full screen. Divisions are
    // signed and truncate toward zero, which matters for a screen size of zero.
    function void project_axis(input int lo, input int hi, input int margin, input int size,
                               output logic [fctc_pkg::BND_W-1:0] b_lo,
                               output logic [fctc_pkg::BND_W-1:0] b_hi);
      int r_span, far_tgt, tgt_span, p_lo, p_hi;
      r_span   = (hi > lo) ? hi - lo : 1;
      far_tgt  = size - 1 - margin;
      tgt_span = (far_tgt > margin) ? far_tgt - margin : 1;
      p_lo = lo - (margin * r_span + tgt_span / 2) / tgt_span;
      p_hi = p_lo + ((size - 1) * r_span + tgt_span / 2) / tgt_span;
      p_lo = clamp_raw(p_lo);
      p_hi = clamp_raw(p_hi);
      if (p_hi <= p_lo) p_hi = p_lo + 1;
      b_lo = p_lo[fctc_pkg::BND_W-1:0];
      b_hi = p_hi[fctc_pkg::BND_W-1:0];
    endfunction

    function void note_point(logic [fctc_pkg::RAW_W-1:0] x, logic [fctc_pkg::RAW_W-1:0] y);
      int left_x, right_x, top_x, bot_x, left_y, right_y, top_y, bot_y;
      int ax_l, ax_r, ay_t, ay_b;
      cal_result_t res;
      corner_x[slot] = x;
      corner_y[slot] = y;
      if (slot == 2'd3) begin
        left_x  = (int'(corner_x[0]) + int'(corner_x[2])) >> 1;
        right_x = (int'(corner_x[1]) + int'(corner_x[3])) >> 1;
        top_x   = (int'(corner_x[0]) + int'(corner_x[1])) >> 1;
        bot_x   = (int'(corner_x[2]) + int'(corner_x[3])) >> 1;
        left_y  = (int'(corner_y[0]) + int'(corner_y[2])) >> 1;
        right_y = (int'(corner_y[1]) + int'(corner_y[3])) >> 1;
        top_y   = (int'(corner_y[0]) + int'(corner_y[1])) >> 1;
        bot_y   = (int'(corner_y[2]) + int'(corner_y[3])) >> 1;
        res.swap_axes = (abs_diff(right_y, left_y) + abs_diff(bot_x, top_x)) >
                        (abs_diff(right_x, left_x) + abs_diff(bot_y, top_y));
        ax_l = res.swap_axes ? left_y : left_x;
        ax_r = res.swap_axes ? right_y : right_x;
        ay_t = res.swap_axes ? top_x : top_y;
        ay_b = res.swap_axes ? bot_x : bot_y;
        res.flip_x = ax_r < ax_l;
        res.flip_y = ay_b < ay_t;
        project_axis(res.flip_x ? ax_r : ax_l, res.flip_x ? ax_l : ax_r,
                     int'(margin_x), int'(scr_width), res.x_low_bound, res.x_high_bound);
        project_axis(res.flip_y ? ay_b : ay_t, res.flip_y ? ay_t : ay_b,
                     int'(margin_y), int'(scr_height), res.y_low_bound, res.y_high_bound);
        res.ranges_ok = (res.x_high_bound > res.x_low_bound) &&
                        (res.y_high_bound > res.y_low_bound) &&
                        (res.x_high_bound - res.x_low_bound >= fctc_pkg::MinSpan) &&
                        (res.y_high_bound - res.y_low_bound >= fctc_pkg::MinSpan);
        expected_q.push_back(res);
      end
      slot = slot + 2'd1;
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        n_errors++;
      end
    endfunction

    function void check_result(cal_result_t got);
      cal_result_t want;
      n_results++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        n_errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("x_low_bound", int'(want.x_low_bound), int'(got.x_low_bound));
      compare_field("x_high_bound", int'(want.x_high_bound), int'(got.x_high_bound));
      compare_field("y_low_bound", int'(want.y_low_bound), int'(got.y_low_bound));
      compare_field("y_high_bound", int'(want.y_high_bound), int'(got.y_high_bound));
      compare_field("swap_axes", int'(want.swap_axes), int'(got.swap_axes));
      compare_field("flip_x", int'(want.flip_x), int'(got.flip_x));
      compare_field("flip_y", int'(want.flip_y), int'(got.flip_y));
      compare_field("ranges_ok", int'(want.ranges_ok), int'(got.ranges_ok));
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [fctc_pkg::IDX_W-1:0] cfg_idx_i;
  logic [fctc_pkg::CFG_W-1:0] cfg_data_i;

  fctc_point_if pt_if ();
  fctc_cal_if   cal_if ();

  four_corner_touch_calibration dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pt_i       (pt_if),
    .cal_o      (cal_if)
  );

  cal_scoreboard sb = new();

  int burst_left = 0;      // items left in the current sender burst
  int points_sent = 0;
  int settings_used = 1;   // the reset values count as the first setting

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sends one raw point and waits until the block takes it. The sender works in bursts
  // of random length; between bursts valid is dropped for a random number of cycles,
  // and sometimes not at all, so that back-to-back items also occur.
  task automatic send_point(input logic [fctc_pkg::RAW_W-1:0] x,
                            input logic [fctc_pkg::RAW_W-1:0] y);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 3) == 0) gap = 0;
      else if ($urandom_range(0, 3) == 0) gap = $urandom_range(4, 20);
      else gap = $urandom_range(1, 3);
      if (gap > 0) begin
        pt_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    pt_if.valid <= 1'b1;
    pt_if.raw_x <= x;
    pt_if.raw_y <= y;
    // Signals read right after the edge still hold their values from before it.
    @(posedge clk_i);
    while (!pt_if.ready) @(posedge clk_i);
    sb.note_point(x, y);
    points_sent++;
  endtask

  // Sends one point with random readings on both channels.
  task automatic send_noise();
    int nx, ny;
    nx = $urandom_range(0, 4095);
    ny = $urandom_range(0, 4095);
    send_point(nx[fctc_pkg::RAW_W-1:0], ny[fctc_pkg::RAW_W-1:0]);
  endtask

  // Drops valid, waits for every expected result and then for the block to go quiet.
  task automatic settle();
    pt_if.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [fctc_pkg::IDX_W-1:0] idx,
                           input logic [fctc_pkg::CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    sb.set_reg(idx, data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // A new register setting is only applied with the block idle.
  task automatic apply_config(input int mx, input int my, input int w, input int h);
    settle();
    write_reg(fctc_pkg::CfgMarginX, mx[fctc_pkg::CFG_W-1:0]);
    write_reg(fctc_pkg::CfgMarginY, my[fctc_pkg::CFG_W-1:0]);
    write_reg(fctc_pkg::CfgWidth, w[fctc_pkg::CFG_W-1:0]);
    write_reg(fctc_pkg::CfgHeight, h[fctc_pkg::CFG_W-1:0]);
    settings_used++;
  endtask

  function automatic int jiggle(int v, int amt);
    int r;
    r = v + int'($urandom_range(0, 2 * amt)) - amt;
    if (r < 0) r = 0;
    if (r > int'(fctc_pkg::RawMax)) r = int'(fctc_pkg::RawMax);
    return r;
  endfunction

  // Sends the four corners in the order top-left, top-right, bottom-left, bottom-right.
  // The arguments are the raw readings of the screen edges; with swap set the panel
  // reports screen X on its Y channel and the other way round.
  task automatic send_corners(input int left, input int right, input int top, input int bottom,
                              input bit swap, input int jitter);
    int sx, sy;
    for (int c = 0; c < 4; c++) begin
      sx = jiggle(c[0] ? right : left, jitter);
      sy = jiggle(c[1] ? bottom : top, jitter);
      if (swap) send_point(sy[fctc_pkg::RAW_W-1:0], sx[fctc_pkg::RAW_W-1:0]);
      else send_point(sx[fctc_pkg::RAW_W-1:0], sy[fctc_pkg::RAW_W-1:0]);
    end
  endtask

  // Raw span of one axis: wide like a real panel, anywhere at all, or narrow around the
  // 400 threshold of ranges_ok.
  task automatic pick_span(output int lo, output int hi);
    case ($urandom_range(0, 2))
      0: begin
        lo = $urandom_range(0, 700);
        hi = $urandom_range(3300, 4095);
      end
      1: begin
        lo = $urandom_range(0, 4095);
        hi = $urandom_range(0, 4095);
      end
      default: begin
        lo = $urandom_range(0, 4095);
        hi = jiggle(lo + int'($urandom_range(0, 600)), 0);
      end
    endcase
  endtask

  // Mostly well-formed sets with random orientation and content. A few sets are plain
  // noise, and a stray single point now and then shifts the set boundary.
  task automatic run_sets(input int n_sets);
    int r, x_lo, x_hi, y_lo, y_hi, jitter;
    bit fx, fy, sw;
    for (int i = 0; i < n_sets; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) send_noise();
      if (r < 14) begin
        repeat (4) send_noise();
      end else begin
        pick_span(x_lo, x_hi);
        pick_span(y_lo, y_hi);
        fx = 1'($urandom_range(0, 1));
        fy = 1'($urandom_range(0, 1));
        sw = 1'($urandom_range(0, 1));
        jitter = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
        send_corners(fx ? x_hi : x_lo, fx ? x_lo : x_hi, fy ? y_hi : y_lo, fy ? y_lo : y_hi,
                     sw, jitter);
      end
    end
  endtask

  // Mostly plausible settings, sometimes anything the register widths allow. Margin
  // data may carry bits above the register width, which the block drops.
  task automatic random_config();
    int mx, my, w, h;
    mx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 120);
    my = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 120);
    w  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(2, 1024);
    h  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(2, 1024);
    apply_config(mx, my, w, h);
  endtask

  // Receiver: a stall pattern that switches between long ready stretches, fast toggling,
  // and long stalls, so that results meet stalls in every phase. The accepted results
  // are checked in the same loop.
  initial begin
    int run_left, stall_left;
    cal_result_t got;
    run_left = 0;
    stall_left = 0;
    cal_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && cal_if.valid && cal_if.ready) begin
        got.x_low_bound  = cal_if.x_low_bound;
        got.x_high_bound = cal_if.x_high_bound;
        got.y_low_bound  = cal_if.y_low_bound;
        got.y_high_bound = cal_if.y_high_bound;
        got.swap_axes    = cal_if.swap_axes;
        got.flip_x       = cal_if.flip_x;
        got.flip_y       = cal_if.flip_y;
        got.ranges_ok    = cal_if.ranges_ok;
        sb.check_result(got);
      end
      if (run_left == 0 && stall_left == 0) begin
        case ($urandom_range(0, 3))
          0: run_left = $urandom_range(100, 300);
          1: begin
            run_left = $urandom_range(1, 3);
            stall_left = $urandom_range(1, 3);
          end
          2: begin
            run_left = $urandom_range(1, 10);
            stall_left = $urandom_range(10, 40);
          end
          default: stall_left = 1;
        endcase
      end
      if (run_left > 0) begin
        cal_if.ready <= 1'b1;
        run_left--;
      end else begin
        cal_if.ready <= 1'b0;
        stall_left--;
      end
    end
  end

  // Main stimulus.
  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= fctc_pkg::CfgMarginX;
    cfg_data_i  <= '0;
    pt_if.valid <= 1'b0;
    pt_if.raw_x <= '0;
    pt_if.raw_y <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed sets with the reset setting. All points equal at zero gives a degenerate
    // raw span; all at full scale makes the bounds collapse and the high one reach 4096.
    send_corners(0, 0, 0, 0, 1'b0, 0);
    send_corners(4095, 4095, 4095, 4095, 1'b0, 0);
    // Full-scale panel: plain, inverted on both axes, and with X and Y exchanged.
    send_corners(0, 4095, 0, 4095, 1'b0, 0);
    send_corners(4095, 0, 4095, 0, 1'b0, 0);
    send_corners(0, 4095, 0, 4095, 1'b1, 0);
    // A realistic panel, exchanged and inverted in X, with some noise on the readings.
    send_corners(3800, 300, 250, 3700, 1'b1, 15);

    // Largest margins on the smallest screen: the far target is not beyond the near one.
    apply_config(511, 511, 2, 2);
    run_sets(10);
    // Screen size zero and one with no margin.
    apply_config(0, 0, 0, 1);
    run_sets(10);
    // Widest registers at their largest values.
    apply_config(0, 0, 2047, 2047);
    run_sets(10);
    // Margin data with the unused upper bits set, on a 1024-pixel screen.
    apply_config(2047, 1536 + 200, 1024, 1024);
    run_sets(10);

    for (int p = 0; p < 11; p++) begin
      random_config();
      run_sets(40);
    end

    settle();
    $display("Sent %0d raw points and checked %0d calibration results", points_sent,
             sb.n_results);
    $display("over %0d register settings, with %0d mismatches.", settings_used, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: the slowest correct run takes well under 2 ms.
  initial begin
    #10_000_000;
    $display("Timeout with %0d results outstanding.", sb.pending());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
